/* hw/rtl/dmx_esg_pkg.sv */
// ----------------------------------------------------------------------------
// DMX effect slot generator package
// Shared payload types, register indexes and effect codes.
// ----------------------------------------------------------------------------
package dmx_esg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_SELECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNIVERSE_ID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_GAP    = 3'd6;

    localparam logic [2:0] FX_RAINBOW = 3'd0;
    localparam logic [2:0] FX_RANDOM  = 3'd1;
    localparam logic [2:0] FX_FIRE    = 3'd2;
    localparam logic [2:0] FX_WATER   = 3'd3;
    localparam logic [2:0] FX_RGB     = 3'd4;

    localparam logic [2:0] PH_RB_RED   = 3'd0;
    localparam logic [2:0] PH_RB_GREEN = 3'd1;
    localparam logic [2:0] PH_RB_BLUE  = 3'd2;
    localparam logic [2:0] PH_WT_RED_UP   = 3'd1;
    localparam logic [2:0] PH_WT_GREEN_UP = 3'd2;
    localparam logic [2:0] PH_WT_RED_DN   = 3'd3;
    localparam logic [2:0] PH_WT_GREEN_DN = 3'd4;

    localparam logic [1:0] STEP_RED   = 2'd0;
    localparam logic [1:0] STEP_GREEN = 2'd1;
    localparam logic [1:0] STEP_BLUE  = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [7:0] WATER_RED_PEAK   = 8'd21;
    localparam logic [7:0] WATER_GREEN_PEAK = 8'd170;
    localparam logic [7:0] FIRE_RED_BASE    = 8'd150;
    localparam logic [7:0] FIRE_GREEN_BASE  = 8'd69;

    typedef struct packed {
        logic [7:0] random_a;
        logic [7:0] random_b;
        logic [7:0] random_c;
    } tick_t;

    typedef struct packed {
        logic [7:0]  out_universe;
        logic [15:0] out_address;
        logic [7:0]  out_value;
        logic        out_last;
    } result_t;

    // One firing tick handed from the front to the back.
    typedef struct packed {
        logic [7:0]  universe;
        logic [15:0] start_addr;
        logic [7:0]  gap;
        logic [4:0]  devs;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } job_t;

endpackage

/* hw/rtl/dmx_effect_slot_generator_top.sv */
// ----------------------------------------------------------------------------
// DMX effect slot generator
// One lighting effect slot driving a row of RGB devices on a DMX universe.
//
//   Channel   Handshake             Payload
//   ticks     push / full           tick   (random_a, random_b, random_c)
//   writes    pop / empty           result (universe, address, value, last)
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick is taken while full is low; the front end updates the effect at once.
// A firing tick becomes a job in a two-entry queue; the back end first loads
// it and then produces 3 x devices writes at one per cycle while the output
// register is empty or being taken by pop.
// full rises while both queue entries are taken; a stalled pop holds the
// output register and stalls only the back end. Reset is asynchronous.
// ----------------------------------------------------------------------------
module dmx_effect_slot_generator_top
    import dmx_esg_pkg::*;
#(
    parameter int MAX_DEVICES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  tick_t                 tick,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    q_full;
    logic    q_empty;
    logic    job_push;
    job_t    job_in;
    job_t    job_head;
    logic    job_pop;
    logic    res_valid;
    logic    tick_en;
    logic    cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign full      = q_full;
    assign tick_en   = push && !q_full;
    assign empty     = !res_valid;

    dmx_esg_front #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .tick_en   (tick_en),
        .tick_in   (tick),
        .job_push  (job_push),
        .job_out   (job_in)
    );

    dmx_esg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job_in),
        .q_full  (q_full),
        .rd_en   (job_pop),
        .rd_job  (job_head),
        .q_empty (q_empty)
    );

    dmx_esg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (job_head),
        .q_pop     (job_pop),
        .res_out   (result),
        .res_valid (res_valid),
        .res_take  (pop)
    );

endmodule

/* hw/rtl/dmx_esg_queue.sv */
// ----------------------------------------------------------------------------
// DMX effect slot job queue
// Two-entry queue of firing-tick jobs between the front and the back.
// ----------------------------------------------------------------------------
module dmx_esg_queue
    import dmx_esg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output job_t rd_job,
    output logic q_empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* hw/rtl/dmx_esg_front.sv */
// ----------------------------------------------------------------------------
// DMX effect slot front end
// Holds the configuration, divides the tick rate, advances the selected
// effect and emits a job on each firing tick of a known effect with devs > 0.
// ----------------------------------------------------------------------------
module dmx_esg_front
    import dmx_esg_pkg::*;
#(
    parameter int MAX_DEVICES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  tick_en,
    input  tick_t                 tick_in,
    output logic                  job_push,
    output job_t                  job_out
);

    logic        slot_active_reg,   slot_active_next;
    logic [2:0]  effect_select_reg, effect_select_next;
    logic [7:0]  tick_divider_reg,  tick_divider_next;
    logic [15:0] start_address_reg, start_address_next;
    logic [7:0]  universe_id_reg,   universe_id_next;
    logic [4:0]  device_count_reg,  device_count_next;
    logic [7:0]  device_gap_reg,    device_gap_next;

    logic [7:0]  tick_count_reg,   tick_count_next;
    logic [7:0]  level_red_reg,    level_red_next;
    logic [7:0]  level_green_reg,  level_green_next;
    logic [7:0]  level_blue_reg,   level_blue_next;
    logic [2:0]  effect_phase_reg, effect_phase_next;
    logic [7:0]  water_red_reg,    water_red_next;
    logic [7:0]  water_green_reg,  water_green_next;
    logic [1:0]  rgb_step_reg,     rgb_step_next;

    logic        fire;
    logic        known_effect;
    logic [4:0]  devs;
    logic [15:0] rb_prod;
    logic [5:0]  rb_quot;
    logic [7:0]  rb_rem;
    logic [2:0]  wt_phase;
    logic [7:0]  wt_red;
    logic [7:0]  wt_green;

    assign devs = (device_count_reg > 5'(MAX_DEVICES)) ? 5'(MAX_DEVICES) : device_count_reg;

    // random_b mod 5 by reciprocal multiplication; exact for 8-bit values.
    assign rb_prod = 16'(tick_in.random_b) * 16'd205;
    assign rb_quot = rb_prod[15:10];
    assign rb_rem  = tick_in.random_b - (8'(rb_quot) * 8'd5);

    assign fire = (tick_count_reg >= tick_divider_reg);

    always_comb
    begin
        slot_active_next   = slot_active_reg;
        effect_select_next = effect_select_reg;
        tick_divider_next  = tick_divider_reg;
        start_address_next = start_address_reg;
        universe_id_next   = universe_id_reg;
        device_count_next  = device_count_reg;
        device_gap_next    = device_gap_reg;
        tick_count_next    = tick_count_reg;
        level_red_next     = level_red_reg;
        level_green_next   = level_green_reg;
        level_blue_next    = level_blue_reg;
        effect_phase_next  = effect_phase_reg;
        water_red_next     = water_red_reg;
        water_green_next   = water_green_reg;
        rgb_step_next      = rgb_step_reg;
        known_effect       = 1'b0;
        wt_phase           = effect_phase_reg;
        wt_red             = water_red_reg;
        wt_green           = water_green_reg;

        if (cfg_we && cfg_idx <= REG_DEVICE_GAP)
        begin
            case (cfg_idx)
                REG_SLOT_ACTIVE:   slot_active_next   = cfg_wdata[0];
                REG_EFFECT_SELECT: effect_select_next = cfg_wdata[2:0];
                REG_TICK_DIVIDER:  tick_divider_next  = cfg_wdata[7:0];
                REG_START_ADDRESS: start_address_next = cfg_wdata;
                REG_UNIVERSE_ID:   universe_id_next   = cfg_wdata[7:0];
                REG_DEVICE_COUNT:  device_count_next  = cfg_wdata[4:0];
                REG_DEVICE_GAP:    device_gap_next    = cfg_wdata[7:0];
                default:           slot_active_next   = slot_active_reg;
            endcase
            // Any write to a defined register restarts the effect that is now selected.
            case (effect_select_next)
                FX_RAINBOW:
                begin
                    level_red_next    = 8'd255;
                    level_green_next  = 8'd0;
                    level_blue_next   = 8'd0;
                    effect_phase_next = PH_RB_RED;
                end
                FX_WATER:
                begin
                    water_red_next    = 8'd0;
                    water_green_next  = 8'd0;
                    effect_phase_next = 3'd0;
                end
                FX_RGB:  rgb_step_next = STEP_RED;
                default: rgb_step_next = rgb_step_reg;
            endcase
            tick_count_next = tick_divider_next;
        end
        else if (tick_en && slot_active_reg)
        begin
            tick_count_next = fire ? 8'd0 : tick_count_reg + 8'd1;
            if (fire)
            begin
                known_effect = 1'b1;
                case (effect_select_reg)
                    FX_RAINBOW:
                    begin
                        case (effect_phase_reg)
                            PH_RB_RED:
                            begin
                                if (level_red_reg > 8'd1)
                                begin
                                    level_red_next   = level_red_reg - 8'd1;
                                    level_green_next = level_green_reg + 8'd1;
                                end
                                else
                                begin
                                    effect_phase_next = PH_RB_GREEN;
                                end
                            end
                            PH_RB_GREEN:
                            begin
                                if (level_green_reg > 8'd1)
                                begin
                                    level_green_next = level_green_reg - 8'd1;
                                    level_blue_next  = level_blue_reg + 8'd1;
                                end
                                else
                                begin
                                    effect_phase_next = PH_RB_BLUE;
                                end
                            end
                            PH_RB_BLUE:
                            begin
                                if (level_blue_reg > 8'd1)
                                begin
                                    level_blue_next = level_blue_reg - 8'd1;
                                    level_red_next  = level_red_reg + 8'd1;
                                end
                                else
                                begin
                                    effect_phase_next = PH_RB_RED;
                                end
                            end
                            default: effect_phase_next = effect_phase_reg;
                        endcase
                    end
                    FX_RANDOM:
                    begin
                        level_red_next   = tick_in.random_a;
                        level_green_next = tick_in.random_b;
                        level_blue_next  = tick_in.random_c;
                    end
                    FX_FIRE:
                    begin
                        level_red_next   = FIRE_RED_BASE + {2'b00, tick_in.random_a[5:0]};
                        level_green_next = FIRE_GREEN_BASE + {3'b000, tick_in.random_b[4:0]};
                        level_blue_next  = 8'd0;
                    end
                    FX_WATER:
                    begin
                        // A new wave picks its color from the coin bit, then rises
                        // to its peak and falls back to zero.
                        if (water_red_reg == 8'd0 && water_green_reg == 8'd0)
                        begin
                            wt_phase = tick_in.random_a[0] ? PH_WT_RED_UP : PH_WT_GREEN_UP;
                        end
                        if (water_red_reg == WATER_RED_PEAK)
                        begin
                            wt_phase = PH_WT_RED_DN;
                        end
                        if (water_green_reg == WATER_GREEN_PEAK)
                        begin
                            wt_phase = PH_WT_GREEN_DN;
                        end
                        case (wt_phase)
                            PH_WT_RED_UP:   wt_red   = water_red_reg + 8'd1;
                            PH_WT_GREEN_UP: wt_green = water_green_reg + 8'd1;
                            PH_WT_RED_DN:   wt_red   = water_red_reg - 8'd1;
                            PH_WT_GREEN_DN: wt_green = water_green_reg - 8'd1;
                            default:        wt_red   = water_red_reg;
                        endcase
                        effect_phase_next = wt_phase;
                        water_red_next    = wt_red;
                        water_green_next  = wt_green;
                        level_red_next    = (wt_red >= rb_rem) ? wt_red - rb_rem : 8'd0;
                        level_green_next  = (wt_green >= rb_rem) ? wt_green - rb_rem : 8'd0;
                        level_blue_next   = 8'd255 - rb_rem;
                    end
                    FX_RGB:
                    begin
                        case (rgb_step_reg)
                            STEP_GREEN:
                            begin
                                level_red_next   = 8'd0;
                                level_green_next = 8'd255;
                                level_blue_next  = 8'd0;
                                rgb_step_next    = STEP_BLUE;
                            end
                            STEP_BLUE:
                            begin
                                level_red_next   = 8'd0;
                                level_green_next = 8'd0;
                                level_blue_next  = 8'd255;
                                rgb_step_next    = STEP_RED;
                            end
                            default:
                            begin
                                level_red_next   = 8'd255;
                                level_green_next = 8'd0;
                                level_blue_next  = 8'd0;
                                rgb_step_next    = STEP_GREEN;
                            end
                        endcase
                    end
                    default: known_effect = 1'b0;
                endcase
            end
        end
    end

    assign job_push = tick_en && !cfg_we && slot_active_reg && fire && known_effect
                      && (devs != 5'd0);

    always_comb
    begin
        job_out.universe   = universe_id_reg;
        job_out.start_addr = start_address_reg;
        job_out.gap        = device_gap_reg;
        job_out.devs       = devs;
        job_out.red        = level_red_next;
        job_out.green      = level_green_next;
        job_out.blue       = level_blue_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_active_reg   <= 1'b0;
            effect_select_reg <= FX_RAINBOW;
            tick_divider_reg  <= 8'd0;
            start_address_reg <= 16'd0;
            universe_id_reg   <= 8'd0;
            device_count_reg  <= 5'd0;
            device_gap_reg    <= 8'd0;
            tick_count_reg    <= 8'd0;
            level_red_reg     <= 8'd255;
            level_green_reg   <= 8'd0;
            level_blue_reg    <= 8'd0;
            effect_phase_reg  <= 3'd0;
            water_red_reg     <= 8'd0;
            water_green_reg   <= 8'd0;
            rgb_step_reg      <= STEP_RED;
        end
        else
        begin
            slot_active_reg   <= slot_active_next;
            effect_select_reg <= effect_select_next;
            tick_divider_reg  <= tick_divider_next;
            start_address_reg <= start_address_next;
            universe_id_reg   <= universe_id_next;
            device_count_reg  <= device_count_next;
            device_gap_reg    <= device_gap_next;
            tick_count_reg    <= tick_count_next;
            level_red_reg     <= level_red_next;
            level_green_reg   <= level_green_next;
            level_blue_reg    <= level_blue_next;
            effect_phase_reg  <= effect_phase_next;
            water_red_reg     <= water_red_next;
            water_green_reg   <= water_green_next;
            rgb_step_reg      <= rgb_step_next;
        end
    end

endmodule

/* hw/rtl/dmx_esg_back.sv */
// ----------------------------------------------------------------------------
// DMX effect slot back end
// Expands one job into three channel writes per device, one per cycle while
// the output is empty or being taken, into a single output register.
// ----------------------------------------------------------------------------
module dmx_esg_back
    import dmx_esg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  job_t    q_job,
    output logic    q_pop,
    output result_t res_out,
    output logic    res_valid,
    input  logic    res_take
);

    job_t        cur_reg,       cur_next;
    logic        busy_reg,      busy_next;
    logic [1:0]  chan_reg,      chan_next;
    logic [4:0]  left_reg,      left_next;
    logic [15:0] addr_reg,      addr_next;
    result_t     out_reg,       out_next;
    logic        out_valid_reg, out_valid_next;
    logic        step;
    logic        last_write;
    logic [7:0]  chan_level;

    assign q_pop      = !busy_reg && !q_empty;
    assign step       = busy_reg && (!out_valid_reg || res_take);
    assign last_write = (chan_reg == CH_BLUE) && (left_reg == 5'd1);
    assign res_out    = out_reg;
    assign res_valid  = out_valid_reg;

    always_comb
    begin
        case (chan_reg)
            CH_RED:   chan_level = cur_reg.red;
            CH_GREEN: chan_level = cur_reg.green;
            default:  chan_level = cur_reg.blue;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        chan_next      = chan_reg;
        left_next      = left_reg;
        addr_next      = addr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (res_take)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            cur_next  = q_job;
            busy_next = 1'b1;
            chan_next = CH_RED;
            left_next = q_job.devs;
            addr_next = q_job.start_addr;
        end
        else if (step)
        begin
            out_next.out_universe = cur_reg.universe;
            out_next.out_address  = addr_reg;
            out_next.out_value    = chan_level;
            out_next.out_last     = last_write;
            out_valid_next        = 1'b1;
            if (chan_reg == CH_BLUE)
            begin
                // The gap is skipped after the blue channel of each device.
                chan_next = CH_RED;
                left_next = left_reg - 5'd1;
                addr_next = addr_reg + 16'd1 + {8'd0, cur_reg.gap};
                busy_next = !last_write;
            end
            else
            begin
                chan_next = chan_reg + 2'd1;
                addr_next = addr_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            chan_reg      <= CH_RED;
            left_reg      <= 5'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            chan_reg      <= chan_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        addr_reg <= addr_next;
        out_reg  <= out_next;
    end

endmodule
